// ===== rtl/swps_pkg.sv =====
// ============================================================================
// swps_pkg - shared types and constants
// Field widths, stream bus widths and control states for the sliding window
// period statistics block.
// ============================================================================
package swps_pkg;

    localparam int TIME_W      = 20;   // one frame time, microseconds
    localparam int COUNT_W     = 9;    // sample_count field
    localparam int IN_TDATA_W  = 24;   // 20 bits padded to whole bytes
    localparam int OUT_TDATA_W = 96;   // 9 + 4 * 20 = 89 bits padded

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [1:0] {
        ST_IDLE,    // waiting for a sample
        ST_SCAN,    // rotating the chain, min/max and divide running
        ST_WAIT     // scan finished, waiting on divider or output slot
    } swps_state_t;

endpackage

// ===== rtl/sliding_window_period_stats.sv =====
// Sequence: after an input transaction the chain rotates over all WINDOW cells
//   for the min/max scan while the serial divider runs alongside it.
// Pacing: no new sample is taken until the result is loaded into the output
//   register; the chain rotation sets the pace, and a busy output slot holds it.
// Reset: synchronous active-low aresetn clears count, sum, control and output
//   valid; window cells are not cleared and hold nothing until written.
// ============================================================================
// sliding_window_period_stats - windowed frame time statistics
// Keeps the last WINDOW frame times in a chain of cells and reports count,
// average, minimum, maximum and jitter after every sample.
// ============================================================================
module sliding_window_period_stats #(
    parameter int WINDOW = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: [19:0] frame_time
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [swps_pkg::IN_TDATA_W-1:0]       s_tdata,
    // m_tdata: [8:0] sample_count, [28:9] average_time, [48:29] minimum_time,
    //          [68:49] maximum_time, [88:69] jitter_time, [95:89] zero
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [swps_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import swps_pkg::*;

    // Count holds 0..WINDOW; the sum of WINDOW samples fits TIME_W + log2.
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = TIME_W + $clog2(WINDOW);
    localparam int SCAN_W = $clog2(WINDOW);

    swps_state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // Control outputs of the sequencer
    // ------------------------------------------------------------------
    logic in_take;      // input transaction this cycle
    logic rotate;       // chain recirculates one step
    logic div_start;    // launch divider on the updated sum and count
    logic out_load;     // capture the result into the output register

    logic              div_busy;
    time_t             div_quot;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SCAN_W-1:0] scan_reg;
    time_t             min_reg, max_reg;
    logic              scan_last;
    logic              tail_valid;

    logic              m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // ------------------------------------------------------------------
    // Chain of cells. Cell 0 is the newest sample, the last cell the oldest.
    // On a transaction the new sample enters cell 0 and the oldest falls out
    // of the tail. During the scan the tail feeds back into cell 0, so after
    // WINDOW steps every cell is back in place.
    // ------------------------------------------------------------------
    time_t cell_q [WINDOW];
    time_t head_in;
    time_t sample;
    logic  chain_shift;

    assign sample      = s_tdata[TIME_W-1:0];
    assign head_in     = in_take ? sample : cell_q[WINDOW-1];
    assign chain_shift = in_take | rotate;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        time_t cell_d;
        if (i == 0) begin : g_head
            assign cell_d = head_in;
        end else begin : g_body
            assign cell_d = cell_q[i-1];
        end
        swps_cell u_cell (
            .aclk     (aclk),
            .shift_en (chain_shift),
            .d_in     (cell_d),
            .d_out    (cell_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Sample count and running sum. When the window is full the tail cell
    // holds the oldest sample, which leaves the sum as the new one enters.
    // ------------------------------------------------------------------
    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg + SUM_W'(sample);
        if (count_reg == CNT_W'(WINDOW)) begin
            sum_next = sum_next - SUM_W'(cell_q[WINDOW-1]);
        end else begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (in_take) begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Min/max scan. At scan step k the tail shows the cell that sat at
    // position WINDOW-1-k; it is a held sample when that position is below
    // the count, i.e. k >= WINDOW - count.
    // ------------------------------------------------------------------
    assign scan_last  = (scan_reg == SCAN_W'(WINDOW - 1));
    assign tail_valid = (CNT_W'(scan_reg) >= (CNT_W'(WINDOW) - count_reg));

    always_ff @(posedge aclk) begin
        if (in_take) begin
            scan_reg <= '0;
            min_reg  <= TIME_MAX;
            max_reg  <= '0;
        end else if (rotate) begin
            scan_reg <= scan_reg + 1'b1;
            if (tail_valid) begin
                if (cell_q[WINDOW-1] < min_reg) begin
                    min_reg <= cell_q[WINDOW-1];
                end
                if (cell_q[WINDOW-1] > max_reg) begin
                    max_reg <= cell_q[WINDOW-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Average: serial divide of the sum by the count, run during the scan.
    // ------------------------------------------------------------------
    swps_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!div_busy && (!m_tvalid_reg || m_tready)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        rotate    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SCAN: begin
                rotate    = 1'b1;
                div_start = (scan_reg == '0);
            end
            ST_WAIT: begin
                out_load = !div_busy && (!m_tvalid_reg || m_tready);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign in_take = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: the result waits here while the next sample is taken.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {7'b0, max_reg - min_reg, max_reg, min_reg, div_quot,
                            COUNT_W'(count_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/swps_cell.sv =====
// ============================================================================
// swps_cell - one window cell
// Holds one sample and passes it to the next cell when the chain shifts.
// ============================================================================
module swps_cell (
    input  logic          aclk,
    input  logic          shift_en,
    input  swps_pkg::time_t d_in,
    output swps_pkg::time_t d_out
);
    import swps_pkg::*;

    time_t data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= d_in;
        end
    end

    assign d_out = data_reg;

endmodule

// ===== rtl/swps_div.sv =====
// ============================================================================
// swps_div - serial restoring divider
// One quotient bit per cycle; the dividend register fills with the quotient.
// ============================================================================
module swps_div #(
    parameter int SUM_W = 28,
    parameter int CNT_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             busy,
    output swps_pkg::time_t  quotient
);
    import swps_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb begin
        trial    = {rem_reg, dvd_reg[SUM_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dvd_next = {dvd_reg[SUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    // Quotient never exceeds the largest sample, so the low bits hold it all.
    assign quotient = dvd_reg[TIME_W-1:0];

endmodule
